// ===== rtl/dpt_pkg.sv =====
// package for the dual pulse tone channel: action codes, register offsets,
// mute limit, reset duty patterns and the channel command struct
// no dependencies
`timescale 1ns / 1ps

package dpt_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_QUARTER = 2'd2,
        ACT_HALF    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_CTRL   = 2'd0,
        REG_SWEEP  = 2'd1,
        REG_PER_LO = 2'd2,
        REG_PER_HI = 2'd3
    } reg_sel_t;

    localparam int unsigned PERIOD_W  = 12;
    localparam int unsigned SAMPLE_W  = 4;
    localparam int unsigned DUTY_W    = 32;
    localparam logic [PERIOD_W-1:0] MUTE_LIMIT = 12'h78B;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = 12'd8;
    localparam logic [DUTY_W-1:0]   DUTY_RESET = 32'h9F78_6040;

    // one command per transfer, fanned out to both channels
    typedef struct packed {
        logic       advance;
        action_t    action;
        logic       chan;
        reg_sel_t   reg_sel;
        logic [7:0] data;
    } chan_cmd_t;

endpackage

// ===== rtl/dpt_if.sv =====
// handshake interfaces for the item channel and the result channel
// depends on nothing
`timescale 1ns / 1ps

interface dpt_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [2:0] reg_addr;
    logic [7:0] write_data;

    modport source (output valid, action, reg_addr, write_data, input ready);
    modport sink   (input valid, action, reg_addr, write_data, output ready);
endinterface

interface dpt_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] sample_one;
    logic [3:0] sample_two;

    modport source (output valid, sample_one, sample_two, input ready);
    modport sink   (input valid, sample_one, sample_two, output ready);
endinterface

// ===== rtl/dual_pulse_tone_channel.sv =====
// top level of the dual pulse tone channel: input register, two channels,
// result register; depends on dpt_pkg, dpt_if and dpt_channel
`timescale 1ns / 1ps

// Two square-wave tone channels driven by a stream of actions (register
// write, timer tick, quarter-frame clock, half-frame clock). Every accepted
// transfer returns one result holding both channels' 4-bit samples after the
// action. An item lands in an input register, the channel state update and
// the sample lookup run in one combinational pass, and the samples go into a
// result register, so a result is offered only after its item has passed
// both registers; a new item is taken every clock while the result register
// is free or being read, the pace set by that single pass through the sweep
// add/subtract and the mute compare. Input ready is high while the input
// register is empty or its item moves on in this cycle, so once both
// registers hold data it follows result ready combinationally; with result
// ready held low the block takes two transfers and then stalls its input.
// The duty pattern register may be written only while no item is in flight.
module dual_pulse_tone_channel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [dpt_pkg::DUTY_W-1:0]  cfg_write_data,
    dpt_item_if.sink                    item,
    dpt_result_if.source                result
);
    import dpt_pkg::*;

    // duty patterns, one byte per pattern
    logic [DUTY_W-1:0] duty_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] in_action_reg;
    logic [2:0] in_addr_reg;
    logic [7:0] in_data_reg;

    // result register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_one_reg;
    logic [SAMPLE_W-1:0] out_two_reg;

    logic                advance;
    logic                out_free;
    chan_cmd_t           cmd;
    logic [SAMPLE_W-1:0] sample_one_next;
    logic [SAMPLE_W-1:0] sample_two_next;

    // result register can take a new sample pair
    assign out_free   = !out_valid_reg || result.ready;
    // the registered item is processed and retired this cycle
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || advance;

    always_comb
    begin
        cmd.advance = advance;
        cmd.action  = action_t'(in_action_reg);
        cmd.chan    = in_addr_reg[2];
        cmd.reg_sel = reg_sel_t'(in_addr_reg[1:0]);
        cmd.data    = in_data_reg;
    end

    // channel one: negative sweep subtracts the plain shifted period
    dpt_channel u_chan_one (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .second        (1'b0),
        .duty_patterns (duty_reg),
        .sample        (sample_one_next)
    );

    // channel two: negative sweep subtracts one more
    dpt_channel u_chan_two (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .second        (1'b1),
        .duty_patterns (duty_reg),
        .sample        (sample_two_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= DUTY_RESET;
        else if (cfg_write_en)
            duty_reg <= cfg_write_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_action_reg <= item.action;
            in_addr_reg   <= item.reg_addr;
            in_data_reg   <= item.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_one_reg <= sample_one_next;
            out_two_reg <= sample_two_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_one = out_one_reg;
    assign result.sample_two = out_two_reg;

    // a retired item always shows up as a result in the next cycle
    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("retired item produced no result");

    // a stalled item in the input register stays there
    a_stalled_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled item lost");

    // no transfer overwrites an item that is not being retired
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(item.valid && item.ready && in_valid_reg && !advance))
        else $error("input register overwritten");

endmodule

// ===== rtl/dpt_channel.sv =====
// one pulse tone channel: timer, duty sequencer, envelope, sweep, length
// depends on dpt_pkg
`timescale 1ns / 1ps

module dpt_channel (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dpt_pkg::chan_cmd_t              cmd,
    input  logic                            second,
    input  logic [dpt_pkg::DUTY_W-1:0]      duty_patterns,
    output logic [dpt_pkg::SAMPLE_W-1:0]    sample
);
    import dpt_pkg::*;

    typedef struct packed {
        logic [1:0]          duty_select;
        logic                loop_halt_flag;
        logic                constant_flag;
        logic [3:0]          volume_period;
        logic                envelope_restart;
        logic                sweep_on;
        logic [2:0]          sweep_period;
        logic                sweep_down;
        logic [2:0]          sweep_amount;
        logic                sweep_restart;
        logic [PERIOD_W-1:0] period;
        logic [4:0]          length_left;
        logic [PERIOD_W-1:0] period_count;
        logic [2:0]          step_position;
        logic [2:0]          sweep_count;
        logic [3:0]          env_divider;
        logic [3:0]          envelope_level;
    } chan_state_t;

    chan_state_t st_reg, st_next;

    logic                silenced;
    logic [PERIOD_W-1:0] delta;
    logic [PERIOD_W:0]   sub_amt;
    logic [PERIOD_W-1:0] down_period;
    logic [PERIOD_W:0]   up_sum;
    logic [PERIOD_W-1:0] swept_period;
    logic                silenced_next;
    logic [7:0]          pattern;
    logic [3:0]          level;

    // sweep target
    always_comb
    begin
        silenced = (st_reg.period < MIN_PERIOD)
                 || (!st_reg.sweep_down && (st_reg.period >= MUTE_LIMIT));
        delta    = st_reg.period >> st_reg.sweep_amount;
        sub_amt  = {1'b0, delta} + {{PERIOD_W{1'b0}}, second};
        down_period = (sub_amt > {1'b0, st_reg.period}) ? '0
                    : (st_reg.period - sub_amt[PERIOD_W-1:0]);
        up_sum   = {1'b0, st_reg.period} + {1'b0, delta};
        swept_period = st_reg.sweep_down ? down_period : up_sum[PERIOD_W-1:0];
    end

    always_comb
    begin
        st_next = st_reg;
        if (cmd.advance)
        begin
            case (cmd.action)
                ACT_WRITE:
                begin
                    if (cmd.chan == second)
                    begin
                        case (cmd.reg_sel)
                            REG_CTRL:
                            begin
                                st_next.duty_select      = cmd.data[7:6];
                                st_next.loop_halt_flag   = cmd.data[5];
                                st_next.constant_flag    = cmd.data[4];
                                st_next.volume_period    = cmd.data[3:0];
                                st_next.envelope_restart = 1'b1;
                            end
                            REG_SWEEP:
                            begin
                                st_next.sweep_on      = cmd.data[7];
                                st_next.sweep_period  = cmd.data[6:4];
                                st_next.sweep_down    = cmd.data[3];
                                st_next.sweep_amount  = cmd.data[2:0];
                                st_next.sweep_restart = 1'b1;
                            end
                            // a write keeps only the 11 register bits, the sweep
                            // carry in the top bit is dropped
                            REG_PER_LO:
                            begin
                                st_next.period = {1'b0, st_reg.period[10:8], cmd.data};
                            end
                            REG_PER_HI:
                            begin
                                st_next.period      = {1'b0, cmd.data[2:0],
                                                       st_reg.period[7:0]};
                                st_next.length_left = cmd.data[7:3];
                            end
                            default:
                            begin
                                st_next = st_reg;
                            end
                        endcase
                    end
                end
                ACT_TICK:
                begin
                    if (st_reg.period_count == '0)
                    begin
                        st_next.period_count  = st_reg.period;
                        st_next.step_position = st_reg.step_position - 3'd1;
                    end
                    else
                    begin
                        st_next.period_count = st_reg.period_count - 1'b1;
                    end
                end
                ACT_QUARTER:
                begin
                    if (st_reg.envelope_restart)
                    begin
                        st_next.env_divider      = st_reg.volume_period;
                        st_next.envelope_level   = 4'hF;
                        st_next.envelope_restart = 1'b0;
                    end
                    else if (st_reg.env_divider != '0)
                    begin
                        st_next.env_divider = st_reg.env_divider - 4'd1;
                    end
                    else
                    begin
                        st_next.env_divider = st_reg.volume_period;
                        if (st_reg.envelope_level != '0)
                            st_next.envelope_level = st_reg.envelope_level - 4'd1;
                        else if (st_reg.loop_halt_flag)
                            st_next.envelope_level = 4'hF;
                    end
                end
                ACT_HALF:
                begin
                    if (st_reg.sweep_on && !silenced)
                    begin
                        if (st_reg.sweep_count != '0)
                        begin
                            st_next.sweep_count = st_reg.sweep_count - 3'd1;
                        end
                        else
                        begin
                            st_next.sweep_count = st_reg.sweep_period;
                            st_next.period      = swept_period;
                        end
                        if (st_reg.sweep_restart)
                        begin
                            st_next.sweep_restart = 1'b0;
                            st_next.sweep_count   = st_reg.sweep_period;
                        end
                    end
                    if (!st_reg.loop_halt_flag && (st_reg.length_left != '0))
                        st_next.length_left = st_reg.length_left - 5'd1;
                end
                default:
                begin
                    st_next = st_reg;
                end
            endcase
        end
    end

    // level after the action of this transfer
    always_comb
    begin
        silenced_next = (st_next.period < MIN_PERIOD)
                      || (!st_next.sweep_down && (st_next.period >= MUTE_LIMIT))
                      || (st_next.length_left == '0);
        pattern = duty_patterns[{st_next.duty_select, 3'b000} +: 8];
        level   = st_next.constant_flag ? st_next.volume_period : st_next.envelope_level;
        sample  = (!silenced_next && pattern[~st_next.step_position]) ? level : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

endmodule

// ===== bench/tb_dual_pulse_tone_channel.sv =====
// testbench for dual_pulse_tone_channel: directed and random action streams
// checked transfer by transfer against a cycle-free model of both tone channels
// depends on rtl/dpt_pkg.sv, rtl/dpt_if.sv and rtl/dual_pulse_tone_channel.sv
`timescale 1ns / 1ps

module tb_dual_pulse_tone_channel;

    import dpt_pkg::*;

    localparam int CHANNELS    = 2;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    localparam logic CH_ONE = 1'b0;
    localparam logic CH_TWO = 1'b1;

    typedef struct {
        action_t    act;
        logic [2:0] addr;
        logic [7:0] data;
    } tone_item_t;

    typedef struct {
        logic [SAMPLE_W-1:0] one;
        logic [SAMPLE_W-1:0] two;
    } sample_pair_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [DUTY_W-1:0]   cfg_write_data;

    dpt_item_if   item_bus ();
    dpt_result_if result_bus ();

    dual_pulse_tone_channel u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item           (item_bus),
        .result         (result_bus)
    );

    // stimulus waiting for the driver, samples waiting for the monitor
    tone_item_t   pending_items[$];
    sample_pair_t expected_samples[$];

    // bench copy of the duty register and of every channel's state
    logic [DUTY_W-1:0]   duty_copy = DUTY_RESET;
    logic [1:0]          duty_sel     [CHANNELS] = '{default: '0};
    logic                loop_halt    [CHANNELS] = '{default: '0};
    logic                const_vol    [CHANNELS] = '{default: '0};
    logic [3:0]          vol_or_rate  [CHANNELS] = '{default: '0};
    logic                env_reload   [CHANNELS] = '{default: '0};
    logic                sweep_en     [CHANNELS] = '{default: '0};
    logic [2:0]          sweep_rate   [CHANNELS] = '{default: '0};
    logic                sweep_neg    [CHANNELS] = '{default: '0};
    logic [2:0]          sweep_amt    [CHANNELS] = '{default: '0};
    logic                sweep_rearm  [CHANNELS] = '{default: '0};
    logic [PERIOD_W-1:0] tone_period  [CHANNELS] = '{default: '0};
    logic [4:0]          length_count [CHANNELS] = '{default: '0};
    logic [PERIOD_W-1:0] timer_count  [CHANNELS] = '{default: '0};
    logic [2:0]          seq_step     [CHANNELS] = '{default: '0};
    logic [2:0]          sweep_div    [CHANNELS] = '{default: '0};
    logic [3:0]          env_div      [CHANNELS] = '{default: '0};
    logic [3:0]          env_vol      [CHANNELS] = '{default: '0};

    int  fail_count     = 0;
    int  accepted_items = 0;
    int  quiet_cycles   = 0;
    bit  idle_on        = 1'b1;
    bit  item_fired     = 1'b0;

    // period too short, or upward sweep target out of range
    function automatic bit period_muted(input int ch);
        return (tone_period[ch] < MIN_PERIOD) ||
               (!sweep_neg[ch] && tone_period[ch] >= MUTE_LIMIT);
    endfunction

    // current output level of one channel from duty step, envelope and mutes
    function automatic logic [3:0] channel_level(input int ch);
        logic [7:0] pattern;
        if (period_muted(ch) || length_count[ch] == 0)
            return 4'd0;
        pattern = duty_copy[{duty_sel[ch], 3'b000} +: 8];
        if (pattern[3'd7 - seq_step[ch]])
            return const_vol[ch] ? vol_or_rate[ch] : env_vol[ch];
        return 4'd0;
    endfunction

    // apply one accepted action and queue the samples it leaves behind
    task automatic advance_channels(input tone_item_t it);
        int unsigned  p;
        int unsigned  delta;
        int unsigned  sub;
        int           ch;
        sample_pair_t pair;
        if (it.act == ACT_WRITE) begin
            ch = it.addr[2];
            case (reg_sel_t'(it.addr[1:0]))
                REG_CTRL:
                begin
                    duty_sel[ch]    = it.data[7:6];
                    loop_halt[ch]   = it.data[5];
                    const_vol[ch]   = it.data[4];
                    vol_or_rate[ch] = it.data[3:0];
                    env_reload[ch]  = 1'b1;
                end
                REG_SWEEP:
                begin
                    sweep_en[ch]    = it.data[7];
                    sweep_rate[ch]  = it.data[6:4];
                    sweep_neg[ch]   = it.data[3];
                    sweep_amt[ch]   = it.data[2:0];
                    sweep_rearm[ch] = 1'b1;
                end
                REG_PER_LO:
                begin
                    // a write drops the sweep carry in the top period bit
                    tone_period[ch] = {1'b0, tone_period[ch][10:8], it.data};
                end
                default:
                begin
                    // raw length value, no lookup; the sequencer keeps running
                    tone_period[ch]  = {1'b0, it.data[2:0], tone_period[ch][7:0]};
                    length_count[ch] = it.data[7:3];
                end
            endcase
        end else begin
            for (ch = 0; ch < CHANNELS; ch++) begin
                case (it.act)
                    ACT_TICK:
                    begin
                        if (timer_count[ch] == 0) begin
                            timer_count[ch] = tone_period[ch];
                            seq_step[ch]    = seq_step[ch] - 3'd1;
                        end else begin
                            timer_count[ch] = timer_count[ch] - 1'b1;
                        end
                    end
                    ACT_QUARTER:
                    begin
                        if (env_reload[ch]) begin
                            env_div[ch]    = vol_or_rate[ch];
                            env_vol[ch]    = 4'hF;
                            env_reload[ch] = 1'b0;
                        end else if (env_div[ch] != 0) begin
                            env_div[ch] = env_div[ch] - 1'b1;
                        end else begin
                            env_div[ch] = vol_or_rate[ch];
                            if (env_vol[ch] != 0)
                                env_vol[ch] = env_vol[ch] - 1'b1;
                            else if (loop_halt[ch])
                                env_vol[ch] = 4'hF;
                        end
                    end
                    default:
                    begin
                        // sweep first; a muted or disabled unit keeps its reload flag
                        if (sweep_en[ch] && !period_muted(ch)) begin
                            if (sweep_div[ch] != 0) begin
                                sweep_div[ch] = sweep_div[ch] - 1'b1;
                            end else begin
                                p             = 32'(tone_period[ch]);
                                delta         = p >> sweep_amt[ch];
                                sweep_div[ch] = sweep_rate[ch];
                                if (sweep_neg[ch]) begin
                                    // channel two subtracts one extra, floor at zero
                                    sub = delta + ((ch == 1) ? 1 : 0);
                                    p   = (sub > p) ? 0 : p - sub;
                                end else begin
                                    p = p + delta;
                                end
                                tone_period[ch] = p[PERIOD_W-1:0];
                            end
                            if (sweep_rearm[ch]) begin
                                sweep_rearm[ch] = 1'b0;
                                sweep_div[ch]   = sweep_rate[ch];
                            end
                        end
                        if (!loop_halt[ch] && length_count[ch] != 0)
                            length_count[ch] = length_count[ch] - 1'b1;
                    end
                endcase
            end
        end
        pair.one = channel_level(0);
        pair.two = channel_level(1);
        expected_samples.push_back(pair);
    endtask

    task automatic queue_item(input action_t act, input logic [2:0] addr,
                              input logic [7:0] data);
        tone_item_t it;
        it.act  = act;
        it.addr = addr;
        it.data = data;
        pending_items.push_back(it);
    endtask

    // drain, rewrite the duty register, then queue a batch of random actions
    task automatic run_phase(input logic [DUTY_W-1:0] pattern, input int count,
                             input bit with_idle);
        tone_item_t it;
        int         roll;
        while (pending_items.size() != 0 || item_bus.valid ||
               expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = pattern;
        duty_copy      = pattern;
        @(negedge clk);
        cfg_write_en = 1'b0;
        idle_on      = with_idle;
        for (int n = 0; n < count; n++) begin
            roll    = $urandom_range(0, 99);
            it.act  = (roll < 20) ? ACT_WRITE :
                      (roll < 70) ? ACT_TICK :
                      (roll < 85) ? ACT_QUARTER : ACT_HALF;
            it.addr = $urandom_range(0, 7);
            it.data = $urandom_range(0, 255);
            if (it.act == ACT_WRITE) begin
                // keep periods short most of the time so the sequencer steps
                if (reg_sel_t'(it.addr[1:0]) == REG_PER_HI && $urandom_range(0, 3) != 0)
                    it.data[2:0] = 3'd0;
                if (reg_sel_t'(it.addr[1:0]) == REG_PER_LO && $urandom_range(0, 1) != 0)
                    it.data = $urandom_range(8, 20);
            end
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender: one transfer offered at a time, random gaps while idling is on
    always @(negedge clk)
    begin : item_driver
        int         send_gap;
        tone_item_t next_item;
        if (rst_n) begin
            if (!item_bus.valid || item_fired) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_bus.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 6) - 1;
                    item_bus.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    item_bus.action     <= next_item.act;
                    item_bus.reg_addr   <= next_item.addr;
                    item_bus.write_data <= next_item.data;
                    item_bus.valid      <= 1'b1;
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off that backs up the
    // pipeline while the sender keeps offering
    always @(negedge clk)
    begin : result_sink
        int stall_left;
        int hold_left;
        bit hold_done;
        if (!hold_done && accepted_items >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            result_bus.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // monitor: check results, predict accepted items, watch for a hang
    always @(posedge clk)
    begin : transfer_monitor
        sample_pair_t want;
        tone_item_t   seen;
        if (rst_n) begin
            item_fired <= item_bus.valid && item_bus.ready;
            if (result_bus.valid && result_bus.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("result transfer with no samples expected");
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (result_bus.sample_one !== want.one) begin
                        $error("sample_one: expected %0d, actual %0d",
                               want.one, result_bus.sample_one);
                        fail_count++;
                    end
                    if (result_bus.sample_two !== want.two) begin
                        $error("sample_two: expected %0d, actual %0d",
                               want.two, result_bus.sample_two);
                        fail_count++;
                    end
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                seen.act  = action_t'(item_bus.action);
                seen.addr = item_bus.reg_addr;
                seen.data = item_bus.write_data;
                advance_channels(seen);
                accepted_items++;
            end
            if ((item_bus.valid && item_bus.ready) ||
                (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        item_bus.valid      = 1'b0;
        item_bus.action     = ACT_WRITE;
        item_bus.reg_addr   = '0;
        item_bus.write_data = '0;
        result_bus.ready    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of every register, each action, the mute edges,
        // zero-shift sweep, negative sweep floor and raw length load
        run_phase(DUTY_RESET, 0, 1'b1);
        queue_item(ACT_WRITE,   {CH_ONE, REG_CTRL},   8'hFF);
        queue_item(ACT_WRITE,   {CH_TWO, REG_CTRL},   8'h00);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_LO}, 8'hFF);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_HI}, 8'hFF);
        queue_item(ACT_WRITE,   {CH_ONE, REG_SWEEP},  8'h88);
        queue_item(ACT_HALF,    3'd7,                 8'hFF);
        queue_item(ACT_WRITE,   {CH_TWO, REG_PER_LO}, 8'h08);
        queue_item(ACT_WRITE,   {CH_TWO, REG_PER_HI}, 8'hF8);
        queue_item(ACT_WRITE,   {CH_TWO, REG_SWEEP},  8'h88);
        queue_item(ACT_QUARTER, 3'd0,                 8'h00);
        queue_item(ACT_HALF,    3'd0,                 8'h00);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_LO}, 8'h8A);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_HI}, 8'h0F);
        queue_item(ACT_WRITE,   {CH_ONE, REG_SWEEP},  8'h70);
        queue_item(ACT_TICK,    3'd0,                 8'h00);
        queue_item(ACT_TICK,    3'd5,                 8'hA5);
        queue_item(ACT_HALF,    3'd2,                 8'h5A);
        queue_item(ACT_QUARTER, 3'd7,                 8'hFF);
        queue_item(ACT_WRITE,   {CH_TWO, REG_SWEEP},  8'hFF);
        queue_item(ACT_WRITE,   {CH_TWO, REG_PER_LO}, 8'h07);
        queue_item(ACT_QUARTER, 3'd1,                 8'h00);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_LO}, 8'h00);
        queue_item(ACT_WRITE,   {CH_ONE, REG_PER_HI}, 8'h00);
        queue_item(ACT_TICK,    3'd3,                 8'h00);

        run_phase('0, 150, 1'b1);
        run_phase('1, 150, 1'b1);
        run_phase($urandom, 600, 1'b1);
        run_phase($urandom, 180, 1'b0);

        while (pending_items.size() != 0 || item_bus.valid ||
               expected_samples.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
